// ===== rtl/core/fqn_pkg.sv =====
`timescale 1ns / 1ps

package fqn_pkg;

	// Width of a normalized magnitude: the largest component lands in [2^29, 2^30).
	localparam int NORM_W = 30;
	// Square of a normalized magnitude.
	localparam int SQ_W = 2 * NORM_W;
	// Sum of two squares.
	localparam int R2_W = SQ_W + 1;
	// Radicand of the first square root (sum of three squares, below 3 * 2^60).
	localparam int SQ1_W = SQ_W + 2;
	// One result bit per square root step.
	localparam int NS1 = SQ1_W / 2;
	// Width of a first stage root (n and rr stay below 2^31).
	localparam int N_W = NS1;
	// Width of n + m and of 2n.
	localparam int HI_W = N_W + 1;
	// Width of n * (n + m).
	localparam int LO_W = N_W + HI_W;
	// Width of one quaternion component on the ports.
	localparam int OUT_W = 32;

	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_ZERO    = 2'd1,
		ST_ALIGNED = 2'd2
	} status_t;

	// Per-sample control that rides along with the datapath.
	typedef struct packed {
		logic    nx;
		logic    ny;
		logic    zpos;
		status_t st;
	} ctrl_t;

endpackage

// ===== rtl/core/force_to_normal_quaternion.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   force_x, force_y, force_z
// output    out        out_valid / out_stall quat_x, quat_y, quat_z, quat_w, status
//
// One force sample is taken per cycle while in_stall is low; results leave at the same rate.
// Most of the pipeline is made up of the chains of square root and division cells; each
// active cell resolves one result bit per cycle while the pipeline advances.
// Reset clears only the valid bits; no clearing pass is needed.
// A stalled output is held in the output register and one more result goes into a
// skid register; in_stall rises only while that skid register is occupied.

module force_to_normal_quaternion #(
	parameter int FORCE_BITS = 24,
	parameter int FRAC_BITS  = 30
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [FORCE_BITS-1:0]         force_x,
	input  logic signed [FORCE_BITS-1:0]         force_y,
	input  logic signed [FORCE_BITS-1:0]         force_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fqn_pkg::OUT_W-1:0]     quat_x,
	output logic signed [fqn_pkg::OUT_W-1:0]     quat_y,
	output logic signed [fqn_pkg::OUT_W-1:0]     quat_z,
	output logic signed [fqn_pkg::OUT_W-1:0]     quat_w,
	output logic [1:0]                           status
);
	import fqn_pkg::*;

	localparam int F     = FRAC_BITS;
	// All four division chains have the length of the longest one.
	localparam int NDIV  = 2 * F;
	localparam int KHI   = 2 * F;
	localparam int KLO   = 2 * F - 1;
	localparam int KU    = F;
	localparam int HV_W  = KHI + 1;
	localparam int LV_W  = KLO + 1;
	localparam int UV_W  = KU + 1;
	// Second square root: radicands up to 2^(2F), roots up to 2^F.
	localparam int RW2   = 2 * F + 2;
	localparam int NS2   = RW2 / 2;
	localparam int PW2   = 2 * UV_W;
	localparam int CW    = $bits(ctrl_t);
	localparam int S1W   = CW + R2_W + 3 * NORM_W;
	localparam int S2W   = CW + 2 * UV_W;
	localparam logic [PW2-1:0]   HALF = PW2'(1) << (F - 1);
	localparam logic [OUT_W-1:0] ONE  = OUT_W'(1) << F;

	typedef struct packed {
		logic [OUT_W-1:0] qx;
		logic [OUT_W-1:0] qy;
		logic [OUT_W-1:0] qw;
		status_t          st;
	} res_t;

	// The whole pipeline advances together while the skid register is free.
	logic en;

	// Front end: magnitudes, common normalization and the sums of squares.
	logic               f_vld;
	logic [SQ1_W-1:0]   f_sum3, f_rb;
	logic [R2_W-1:0]    f_r2;
	logic [NORM_W-1:0]  f_m, f_bx, f_by;
	ctrl_t              f_ctrl;

	fqn_front #(
		.FORCE_BITS(FORCE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.fx      (force_x),
		.fy      (force_y),
		.fz      (force_z),
		.out_vld (f_vld),
		.sum3    (f_sum3),
		.r2      (f_r2),
		.rb      (f_rb),
		.m       (f_m),
		.bx      (f_bx),
		.by      (f_by),
		.ctrl    (f_ctrl)
	);

	// First square root chain. Lane 0 finds n = |(ax, ay, m)|, lane 1 finds
	// rr = |(bx, by)| for the separately normalized axis.
	logic                      vld1  [0:NS1];
	logic [1:0][SQ1_W-1:0]     rad1  [0:NS1];
	logic [1:0][SQ1_W-1:0]     root1 [0:NS1];
	logic [S1W-1:0]            side1 [0:NS1];

	assign vld1[0]  = f_vld;
	assign rad1[0]  = {f_rb, f_sum3};
	assign root1[0] = '0;
	assign side1[0] = {f_ctrl, f_r2, f_m, f_bx, f_by};

	for (genvar i = 0; i < NS1; i++) begin : g_sqrt1
		fqn_sqrt_cell #(
			.RW    (SQ1_W),
			.STEP  (NS1 - 1 - i),
			.LANES (2),
			.SW    (S1W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (vld1[i]),
			.rad_in   (rad1[i]),
			.root_in  (root1[i]),
			.side_in  (side1[i]),
			.vld_out  (vld1[i+1]),
			.rad_out  (rad1[i+1]),
			.root_out (root1[i+1]),
			.side_out (side1[i+1])
		);
	end

	ctrl_t             c1_ctrl;
	logic [R2_W-1:0]   c1_r2;
	logic [NORM_W-1:0] c1_m, c1_bx, c1_by;
	logic [N_W-1:0]    c1_n, c1_rr;

	assign {c1_ctrl, c1_r2, c1_m, c1_bx, c1_by} = side1[NS1];
	assign c1_n  = root1[NS1][0][N_W-1:0];
	assign c1_rr = root1[NS1][1][N_W-1:0];

	// Operand preparation for the divisions. The stage numbers continue those
	// of the front end and do not count the cells of the chains.
	logic              vld_s6, vld_s7, vld_s8;
	ctrl_t             ctrl_s6, ctrl_s7, ctrl_s8;
	logic [R2_W-1:0]   r2_s6, r2_s7, r2_s8;
	logic [NORM_W-1:0] bx_s6, by_s6, bx_s7, by_s7, bx_s8, by_s8;
	logic [N_W-1:0]    n_s6, rr_s6, rr_s7, rr_s8;
	logic [HI_W-1:0]   np_s6, twon_s6, np_s7, twon_s7, np_s8, twon_s8;
	logic [LO_W-1:0]   prod_s7, prod_s8;
	logic              sat_hi_s8, sat_lo_s8, sat_ux_s8, sat_uy_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld1[NS1];
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s6   <= c1_ctrl;
			r2_s6     <= c1_r2;
			bx_s6     <= c1_bx;
			by_s6     <= c1_by;
			n_s6      <= c1_n;
			rr_s6     <= c1_rr;
			np_s6     <= HI_W'(c1_n) + HI_W'(c1_m);
			twon_s6   <= {c1_n, 1'b0};

			ctrl_s7   <= ctrl_s6;
			r2_s7     <= r2_s6;
			bx_s7     <= bx_s6;
			by_s7     <= by_s6;
			rr_s7     <= rr_s6;
			np_s7     <= np_s6;
			twon_s7   <= twon_s6;
			prod_s7   <= LO_W'(n_s6) * LO_W'(np_s6);

			ctrl_s8   <= ctrl_s7;
			r2_s8     <= r2_s7;
			bx_s8     <= bx_s7;
			by_s8     <= by_s7;
			rr_s8     <= rr_s7;
			np_s8     <= np_s7;
			twon_s8   <= twon_s7;
			prod_s8   <= prod_s7;
			// A ratio of one or more saturates the quotient.
			sat_hi_s8 <= np_s7 >= twon_s7;
			sat_lo_s8 <= LO_W'(r2_s7) >= prod_s7;
			sat_ux_s8 <= N_W'(by_s7) >= rr_s7;
			sat_uy_s8 <= N_W'(bx_s7) >= rr_s7;
		end
	end

	// Division chains: H = (n+m)/(2n), L = r2/(n(n+m)), and the axis ux, uy.
	logic            dh_vld [0:NDIV];
	logic [HI_W-1:0] dh_rem [0:NDIV];
	logic [HI_W-1:0] dh_den [0:NDIV];
	logic [KHI-1:0]  dh_quo [0:NDIV];
	logic [CW:0]     dh_side[0:NDIV];

	logic            dl_vld [0:NDIV];
	logic [LO_W-1:0] dl_rem [0:NDIV];
	logic [LO_W-1:0] dl_den [0:NDIV];
	logic [KLO-1:0]  dl_quo [0:NDIV];
	logic            dl_side[0:NDIV];

	logic            dx_vld [0:NDIV];
	logic [N_W-1:0]  dx_rem [0:NDIV];
	logic [N_W-1:0]  dx_den [0:NDIV];
	logic [KU-1:0]   dx_quo [0:NDIV];
	logic            dx_side[0:NDIV];

	logic            dy_vld [0:NDIV];
	logic [N_W-1:0]  dy_rem [0:NDIV];
	logic [N_W-1:0]  dy_den [0:NDIV];
	logic [KU-1:0]   dy_quo [0:NDIV];
	logic            dy_side[0:NDIV];

	assign dh_vld[0]  = vld_s8;
	assign dh_rem[0]  = np_s8;
	assign dh_den[0]  = twon_s8;
	assign dh_quo[0]  = '0;
	assign dh_side[0] = {ctrl_s8, sat_hi_s8};

	assign dl_vld[0]  = vld_s8;
	assign dl_rem[0]  = LO_W'(r2_s8);
	assign dl_den[0]  = prod_s8;
	assign dl_quo[0]  = '0;
	assign dl_side[0] = sat_lo_s8;

	assign dx_vld[0]  = vld_s8;
	assign dx_rem[0]  = N_W'(by_s8);
	assign dx_den[0]  = rr_s8;
	assign dx_quo[0]  = '0;
	assign dx_side[0] = sat_ux_s8;

	assign dy_vld[0]  = vld_s8;
	assign dy_rem[0]  = N_W'(bx_s8);
	assign dy_den[0]  = rr_s8;
	assign dy_quo[0]  = '0;
	assign dy_side[0] = sat_uy_s8;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		fqn_div_cell #(
			.BW(HI_W), .KW(KHI), .ACT(i < KHI), .SW(CW + 1)
		) u_hi (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dh_vld[i]), .rem_in(dh_rem[i]), .den_in(dh_den[i]),
			.quo_in(dh_quo[i]), .side_in(dh_side[i]),
			.vld_out(dh_vld[i+1]), .rem_out(dh_rem[i+1]), .den_out(dh_den[i+1]),
			.quo_out(dh_quo[i+1]), .side_out(dh_side[i+1])
		);

		fqn_div_cell #(
			.BW(LO_W), .KW(KLO), .ACT(i < KLO), .SW(1)
		) u_lo (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dl_vld[i]), .rem_in(dl_rem[i]), .den_in(dl_den[i]),
			.quo_in(dl_quo[i]), .side_in(dl_side[i]),
			.vld_out(dl_vld[i+1]), .rem_out(dl_rem[i+1]), .den_out(dl_den[i+1]),
			.quo_out(dl_quo[i+1]), .side_out(dl_side[i+1])
		);

		fqn_div_cell #(
			.BW(N_W), .KW(KU), .ACT(i < KU), .SW(1)
		) u_ux (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dx_vld[i]), .rem_in(dx_rem[i]), .den_in(dx_den[i]),
			.quo_in(dx_quo[i]), .side_in(dx_side[i]),
			.vld_out(dx_vld[i+1]), .rem_out(dx_rem[i+1]), .den_out(dx_den[i+1]),
			.quo_out(dx_quo[i+1]), .side_out(dx_side[i+1])
		);

		fqn_div_cell #(
			.BW(N_W), .KW(KU), .ACT(i < KU), .SW(1)
		) u_uy (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dy_vld[i]), .rem_in(dy_rem[i]), .den_in(dy_den[i]),
			.quo_in(dy_quo[i]), .side_in(dy_side[i]),
			.vld_out(dy_vld[i+1]), .rem_out(dy_rem[i+1]), .den_out(dy_den[i+1]),
			.quo_out(dy_quo[i+1]), .side_out(dy_side[i+1])
		);
	end

	ctrl_t           cd_ctrl;
	logic            cd_sat_hi;

	assign {cd_ctrl, cd_sat_hi} = dh_side[NDIV];

	// Quotients with saturation applied.
	logic            vld_s9;
	ctrl_t           ctrl_s9;
	logic [HV_W-1:0] hv_s9;
	logic [LV_W-1:0] lv_s9;
	logic [UV_W-1:0] ux_s9, uy_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= dh_vld[NDIV] & dl_vld[NDIV] & dx_vld[NDIV] & dy_vld[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s9 <= cd_ctrl;
			hv_s9   <= cd_sat_hi ? (HV_W'(1) << KHI) : HV_W'(dh_quo[NDIV]);
			lv_s9   <= dl_side[NDIV] ? (LV_W'(1) << KLO) : LV_W'(dl_quo[NDIV]);
			ux_s9   <= dx_side[NDIV] ? (UV_W'(1) << KU) : UV_W'(dx_quo[NDIV]);
			uy_s9   <= dy_side[NDIV] ? (UV_W'(1) << KU) : UV_W'(dy_quo[NDIV]);
		end
	end

	// Second square root chain: the half-angle terms from H (lane 0) and L (lane 1).
	logic                    vld2  [0:NS2];
	logic [1:0][RW2-1:0]     rad2  [0:NS2];
	logic [1:0][RW2-1:0]     root2 [0:NS2];
	logic [S2W-1:0]          side2 [0:NS2];

	assign vld2[0]  = vld_s9;
	assign rad2[0]  = {RW2'(lv_s9), RW2'(hv_s9)};
	assign root2[0] = '0;
	assign side2[0] = {ctrl_s9, ux_s9, uy_s9};

	for (genvar i = 0; i < NS2; i++) begin : g_sqrt2
		fqn_sqrt_cell #(
			.RW    (RW2),
			.STEP  (NS2 - 1 - i),
			.LANES (2),
			.SW    (S2W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (vld2[i]),
			.rad_in   (rad2[i]),
			.root_in  (root2[i]),
			.side_in  (side2[i]),
			.vld_out  (vld2[i+1]),
			.rad_out  (rad2[i+1]),
			.root_out (root2[i+1]),
			.side_out (side2[i+1])
		);
	end

	ctrl_t           c2_ctrl;
	logic [UV_W-1:0] c2_ux, c2_uy, c2_rh, c2_rl;

	assign {c2_ctrl, c2_ux, c2_uy} = side2[NS2];
	assign c2_rh = root2[NS2][0][UV_W-1:0];
	assign c2_rl = root2[NS2][1][UV_W-1:0];

	// For a force pointing along +z the half angle is past 45 degrees, so the
	// roles of the two half-angle terms swap between w and the axis scale.
	logic            vld_s10, vld_s11;
	ctrl_t           ctrl_s10;
	logic [UV_W-1:0] w_s10;
	logic [PW2-1:0]  px_s10, py_s10;
	res_t            res_s11;
	logic [PW2-1:0]  rx_sum, ry_sum;
	logic [OUT_W-1:0] qx_mag, qy_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld2[NS2];
			vld_s11 <= vld_s10;
		end
	end

	// Round the axis products back to the output scale.
	always_comb begin
		rx_sum = px_s10 + HALF;
		ry_sum = py_s10 + HALF;
		qx_mag = OUT_W'(rx_sum[PW2-1:F]);
		qy_mag = OUT_W'(ry_sum[PW2-1:F]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s10 <= c2_ctrl;
			w_s10    <= c2_ctrl.zpos ? c2_rl : c2_rh;
			px_s10   <= PW2'(c2_ux) * PW2'(c2_ctrl.zpos ? c2_rh : c2_rl);
			py_s10   <= PW2'(c2_uy) * PW2'(c2_ctrl.zpos ? c2_rh : c2_rl);

			res_s11.st <= ctrl_s10.st;
			if (ctrl_s10.st == ST_NORMAL) begin
				res_s11.qx <= ctrl_s10.ny ? (~qx_mag + 1'b1) : qx_mag;
				res_s11.qy <= ctrl_s10.nx ? qy_mag : (~qy_mag + 1'b1);
				res_s11.qw <= OUT_W'(w_s10);
			end else begin
				res_s11.qx <= '0;
				res_s11.qy <= '0;
				res_s11.qw <= ONE;
			end
		end
	end

	// Output register and skid register. While the skid register is empty the
	// pipeline moves; a result that meets a stalled output register lands there.
	logic o_vld_q, skid_vld_q, o_free;
	res_t o_res_q, skid_res_q;

	assign en     = !skid_vld_q;
	assign o_free = !o_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q    <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (o_free) begin
				o_vld_q <= vld_s11;
			end else begin
				skid_vld_q <= vld_s11;
			end
		end else if (o_free) begin
			o_vld_q    <= 1'b1;
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (o_free) begin
				o_res_q <= res_s11;
			end else begin
				skid_res_q <= res_s11;
			end
		end else if (o_free) begin
			o_res_q <= skid_res_q;
		end
	end

	assign in_stall  = skid_vld_q;
	assign out_valid = o_vld_q;
	assign quat_x    = $signed(o_res_q.qx);
	assign quat_y    = $signed(o_res_q.qy);
	assign quat_z    = '0;
	assign quat_w    = $signed(o_res_q.qw);
	assign status    = o_res_q.st;

`ifndef SYNTHESIS
	// The skid register is only filled behind a waiting output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> o_vld_q)
		else $error("skid register holds a result while the output register is empty");

	// The skid register fills only when the output was stalled the cycle before.
	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(o_vld_q && out_stall && vld_s11))
		else $error("skid register filled without a stalled output");

	// A result arriving at a stalled, full output register must not be dropped.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s11 && o_vld_q && out_stall) |=> skid_vld_q)
		else $error("result lost at a stalled output");

	// Identity results carry exactly the unit scalar part.
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(o_vld_q && o_res_q.st != ST_NORMAL) |->
		(o_res_q.qw == ONE && o_res_q.qx == '0 && o_res_q.qy == '0))
		else $error("identity result is not the unit quaternion");
`endif

endmodule

// ===== rtl/core/fqn_front.sv =====
`timescale 1ns / 1ps

module fqn_front #(
	parameter int FORCE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [FORCE_BITS-1:0]         fx,
	input  logic [FORCE_BITS-1:0]         fy,
	input  logic [FORCE_BITS-1:0]         fz,
	output logic                          out_vld,
	output logic [fqn_pkg::SQ1_W-1:0]     sum3,
	output logic [fqn_pkg::R2_W-1:0]      r2,
	output logic [fqn_pkg::SQ1_W-1:0]     rb,
	output logic [fqn_pkg::NORM_W-1:0]    m,
	output logic [fqn_pkg::NORM_W-1:0]    bx,
	output logic [fqn_pkg::NORM_W-1:0]    by,
	output fqn_pkg::ctrl_t                ctrl
);
	import fqn_pkg::*;

	localparam int PW   = $clog2(FORCE_BITS);
	localparam int WIDE = FORCE_BITS + NORM_W - 1;

	function automatic logic [FORCE_BITS-1:0] mag_of(input logic [FORCE_BITS-1:0] f);
		return f[FORCE_BITS-1] ? (~f + 1'b1) : f;
	endfunction

	function automatic logic [PW-1:0] msb_pos(input logic [FORCE_BITS-1:0] v);
		logic [PW-1:0] p;
		p = '0;
		for (int i = 0; i < FORCE_BITS; i++) begin
			if (v[i]) begin
				p = PW'(i);
			end
		end
		return p;
	endfunction

	// Shift so that a value whose top bit is at p ends with its top bit at NORM_W-1.
	function automatic logic [NORM_W-1:0] scale(input logic [FORCE_BITS-1:0] v,
			input logic [PW-1:0] p);
		logic [WIDE-1:0] t;
		t = WIDE'(v) << (NORM_W - 1);
		t = t >> p;
		return t[NORM_W-1:0];
	endfunction

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [FORCE_BITS-1:0] mx_s1, my_s1, mz_s1;
	logic [FORCE_BITS-1:0] mx_s2, my_s2, mz_s2;
	ctrl_t                 ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	logic [PW-1:0]         p3_s2, p2_s2;
	logic [NORM_W-1:0]     ax_s3, ay_s3, m_s3, bx_s3, by_s3;
	logic [NORM_W-1:0]     m_s4, bx_s4, by_s4;
	logic [NORM_W-1:0]     m_s5, bx_s5, by_s5;
	logic [SQ_W-1:0]       sxx_s4, syy_s4, szz_s4, bxx_s4, byy_s4;
	logic [SQ1_W-1:0]      sum3_s5, rb_s5;
	logic [R2_W-1:0]       r2_s5;
	ctrl_t                 ctrl_in;

	always_comb begin
		ctrl_in.nx   = fx[FORCE_BITS-1];
		ctrl_in.ny   = fy[FORCE_BITS-1];
		ctrl_in.zpos = !fz[FORCE_BITS-1] && (fz != '0);
		if (fx == '0 && fy == '0) begin
			ctrl_in.st = (fz == '0) ? ST_ZERO : ST_ALIGNED;
		end else begin
			ctrl_in.st = ST_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1   <= mag_of(fx);
			my_s1   <= mag_of(fy);
			mz_s1   <= mag_of(fz);
			ctrl_s1 <= ctrl_in;

			p3_s2   <= msb_pos(mx_s1 | my_s1 | mz_s1);
			p2_s2   <= msb_pos(mx_s1 | my_s1);
			mx_s2   <= mx_s1;
			my_s2   <= my_s1;
			mz_s2   <= mz_s1;
			ctrl_s2 <= ctrl_s1;

			ax_s3   <= scale(mx_s2, p3_s2);
			ay_s3   <= scale(my_s2, p3_s2);
			m_s3    <= scale(mz_s2, p3_s2);
			bx_s3   <= scale(mx_s2, p2_s2);
			by_s3   <= scale(my_s2, p2_s2);
			ctrl_s3 <= ctrl_s2;

			sxx_s4  <= SQ_W'(ax_s3) * SQ_W'(ax_s3);
			syy_s4  <= SQ_W'(ay_s3) * SQ_W'(ay_s3);
			szz_s4  <= SQ_W'(m_s3) * SQ_W'(m_s3);
			bxx_s4  <= SQ_W'(bx_s3) * SQ_W'(bx_s3);
			byy_s4  <= SQ_W'(by_s3) * SQ_W'(by_s3);
			m_s4    <= m_s3;
			bx_s4   <= bx_s3;
			by_s4   <= by_s3;
			ctrl_s4 <= ctrl_s3;

			sum3_s5 <= SQ1_W'(sxx_s4) + SQ1_W'(syy_s4) + SQ1_W'(szz_s4);
			r2_s5   <= R2_W'(sxx_s4) + R2_W'(syy_s4);
			rb_s5   <= SQ1_W'(bxx_s4) + SQ1_W'(byy_s4);
			m_s5    <= m_s4;
			bx_s5   <= bx_s4;
			by_s5   <= by_s4;
			ctrl_s5 <= ctrl_s4;
		end
	end

	assign out_vld = vld_s5;
	assign sum3    = sum3_s5;
	assign r2      = r2_s5;
	assign rb      = rb_s5;
	assign m       = m_s5;
	assign bx      = bx_s5;
	assign by      = by_s5;
	assign ctrl    = ctrl_s5;

endmodule

// ===== rtl/core/fqn_sqrt_cell.sv =====
`timescale 1ns / 1ps

module fqn_sqrt_cell #(
	parameter int RW    = 62,
	parameter int STEP  = 0,
	parameter int LANES = 2,
	parameter int SW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_in,
	input  logic [LANES-1:0][RW-1:0]   rad_in,
	input  logic [LANES-1:0][RW-1:0]   root_in,
	input  logic [SW-1:0]              side_in,
	output logic                       vld_out,
	output logic [LANES-1:0][RW-1:0]   rad_out,
	output logic [LANES-1:0][RW-1:0]   root_out,
	output logic [SW-1:0]              side_out
);
	// Trial bit of this step of the digit-by-digit square root.
	localparam logic [RW-1:0] BIT = RW'(1) << (2 * STEP);

	logic [LANES-1:0][RW-1:0] trial, rad_n, root_n;
	logic                     vld_q;
	logic [LANES-1:0][RW-1:0] rad_q, root_q;
	logic [SW-1:0]            side_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			trial[l] = root_in[l] + BIT;
			if (rad_in[l] >= trial[l]) begin
				rad_n[l]  = rad_in[l] - trial[l];
				root_n[l] = (root_in[l] >> 1) + BIT;
			end else begin
				rad_n[l]  = rad_in[l];
				root_n[l] = root_in[l] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_n;
			root_q <= root_n;
			side_q <= side_in;
		end
	end

	assign vld_out  = vld_q;
	assign rad_out  = rad_q;
	assign root_out = root_q;
	assign side_out = side_q;

endmodule

// ===== rtl/core/fqn_div_cell.sv =====
`timescale 1ns / 1ps

module fqn_div_cell #(
	parameter int BW  = 32,
	parameter int KW  = 60,
	parameter bit ACT = 1'b1,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [BW-1:0] rem_in,
	input  logic [BW-1:0] den_in,
	input  logic [KW-1:0] quo_in,
	input  logic [SW-1:0] side_in,
	output logic          vld_out,
	output logic [BW-1:0] rem_out,
	output logic [BW-1:0] den_out,
	output logic [KW-1:0] quo_out,
	output logic [SW-1:0] side_out
);
	logic [BW:0]   dbl;
	logic [BW-1:0] rem_n;
	logic [KW-1:0] quo_n;
	logic          vld_q;
	logic [BW-1:0] rem_q, den_q;
	logic [KW-1:0] quo_q;
	logic [SW-1:0] side_q;

	// One restoring division step; an inactive cell only forwards its inputs.
	always_comb begin
		dbl = {rem_in, 1'b0};
		if (!ACT) begin
			rem_n = rem_in;
			quo_n = quo_in;
		end else if (dbl >= {1'b0, den_in}) begin
			rem_n = dbl[BW-1:0] - den_in;
			quo_n = {quo_in[KW-2:0], 1'b1};
		end else begin
			rem_n = dbl[BW-1:0];
			quo_n = {quo_in[KW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_n;
			den_q  <= den_in;
			quo_q  <= quo_n;
			side_q <= side_in;
		end
	end

	assign vld_out  = vld_q;
	assign rem_out  = rem_q;
	assign den_out  = den_q;
	assign quo_out  = quo_q;
	assign side_out = side_q;

endmodule
